### rtl/rk4s_pkg.sv
`default_nettype none

package rk4s_pkg;

    // Field and register widths of the block's ports
    localparam int FIELD_W       = 64;
    localparam int ENERGY_W      = 64;
    localparam int STEP_SIZE_W   = 41;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 1;

    localparam logic [STEP_SIZE_W-1:0] STEP_SIZE_RESET = 41'd1099511628;

    // Default fixed-point format (Q23.40 in a 64-bit word)
    localparam int WORD_BITS_DEF = 64;
    localparam int FRAC_BITS_DEF = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b1;

    // Shared unit operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_HALF = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV6 = 3'd4;

    // Working register codes (operand sources and destinations)
    localparam int SEL_W = 5;
    localparam logic [SEL_W-1:0] R_X   = 5'd0;
    localparam logic [SEL_W-1:0] R_P   = 5'd1;
    localparam logic [SEL_W-1:0] R_S   = 5'd2;
    localparam logic [SEL_W-1:0] R_E   = 5'd3;
    localparam logic [SEL_W-1:0] R_DX  = 5'd4;
    localparam logic [SEL_W-1:0] R_T   = 5'd5;
    localparam logic [SEL_W-1:0] R_U   = 5'd6;
    localparam logic [SEL_W-1:0] R_XE  = 5'd7;
    localparam logic [SEL_W-1:0] R_XME = 5'd8;
    localparam logic [SEL_W-1:0] R_XEE = 5'd9;
    localparam logic [SEL_W-1:0] R_K1  = 5'd10;
    localparam logic [SEL_W-1:0] R_K2  = 5'd11;
    localparam logic [SEL_W-1:0] R_K3  = 5'd12;
    localparam logic [SEL_W-1:0] R_K4  = 5'd13;
    localparam logic [SEL_W-1:0] R_L1  = 5'd14;
    localparam logic [SEL_W-1:0] R_L2  = 5'd15;
    localparam logic [SEL_W-1:0] R_L3  = 5'd16;
    localparam logic [SEL_W-1:0] R_L4  = 5'd17;

    // Program counter of one integration step
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd45;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SEL_W-1:0] sa;
        logic [SEL_W-1:0] sb;
        logic [SEL_W-1:0] dst;
    } uop_t;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } alu_rsp_t;

    function automatic uop_t mk_uop(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sa,
                                    input logic [SEL_W-1:0] sb, input logic [SEL_W-1:0] dst);
        uop_t u;
        u.op  = op;
        u.sa  = sa;
        u.sb  = sb;
        u.dst = dst;
        return u;
    endfunction

    // Microcode of one RK4 step; T and U are scratch registers
    function automatic uop_t rk4s_uop(input logic [STEP_W-1:0] idx);
        uop_t u;
        unique case (idx)
            // midpoint and end positions, offsets from the energy
            6'd0:  u = mk_uop(OP_HALF, R_DX,  R_DX, R_T);
            6'd1:  u = mk_uop(OP_ADD,  R_X,   R_T,  R_U);
            6'd2:  u = mk_uop(OP_ADD,  R_X,   R_DX, R_XE);
            6'd3:  u = mk_uop(OP_SUB,  R_U,   R_E,  R_XME);
            6'd4:  u = mk_uop(OP_SUB,  R_XE,  R_E,  R_XEE);
            // k1, l1
            6'd5:  u = mk_uop(OP_SUB,  R_X,   R_E,  R_T);
            6'd6:  u = mk_uop(OP_MUL,  R_T,   R_P,  R_T);
            6'd7:  u = mk_uop(OP_ADD,  R_T,   R_T,  R_T);
            6'd8:  u = mk_uop(OP_MUL,  R_DX,  R_T,  R_K1);
            6'd9:  u = mk_uop(OP_MUL,  R_DX,  R_S,  R_L1);
            // k2
            6'd10: u = mk_uop(OP_HALF, R_L1,  R_L1, R_T);
            6'd11: u = mk_uop(OP_ADD,  R_P,   R_T,  R_T);
            6'd12: u = mk_uop(OP_MUL,  R_XME, R_T,  R_T);
            6'd13: u = mk_uop(OP_ADD,  R_T,   R_T,  R_T);
            6'd14: u = mk_uop(OP_MUL,  R_DX,  R_T,  R_K2);
            // l2
            6'd15: u = mk_uop(OP_HALF, R_K1,  R_K1, R_T);
            6'd16: u = mk_uop(OP_ADD,  R_S,   R_T,  R_T);
            6'd17: u = mk_uop(OP_MUL,  R_DX,  R_T,  R_L2);
            // k3
            6'd18: u = mk_uop(OP_HALF, R_L2,  R_L2, R_T);
            6'd19: u = mk_uop(OP_ADD,  R_P,   R_T,  R_T);
            6'd20: u = mk_uop(OP_MUL,  R_XME, R_T,  R_T);
            6'd21: u = mk_uop(OP_ADD,  R_T,   R_T,  R_T);
            6'd22: u = mk_uop(OP_MUL,  R_DX,  R_T,  R_K3);
            // l3
            6'd23: u = mk_uop(OP_HALF, R_K2,  R_K2, R_T);
            6'd24: u = mk_uop(OP_ADD,  R_S,   R_T,  R_T);
            6'd25: u = mk_uop(OP_MUL,  R_DX,  R_T,  R_L3);
            // k4
            6'd26: u = mk_uop(OP_ADD,  R_P,   R_L3, R_T);
            6'd27: u = mk_uop(OP_MUL,  R_XEE, R_T,  R_T);
            6'd28: u = mk_uop(OP_ADD,  R_T,   R_T,  R_T);
            6'd29: u = mk_uop(OP_MUL,  R_DX,  R_T,  R_K4);
            // l4
            6'd30: u = mk_uop(OP_ADD,  R_S,   R_K3, R_T);
            6'd31: u = mk_uop(OP_MUL,  R_DX,  R_T,  R_L4);
            // new slope
            6'd32: u = mk_uop(OP_ADD,  R_K2,  R_K2, R_T);
            6'd33: u = mk_uop(OP_ADD,  R_K1,  R_T,  R_T);
            6'd34: u = mk_uop(OP_ADD,  R_K3,  R_K3, R_U);
            6'd35: u = mk_uop(OP_ADD,  R_U,   R_K4, R_U);
            6'd36: u = mk_uop(OP_ADD,  R_T,   R_U,  R_T);
            6'd37: u = mk_uop(OP_DIV6, R_T,   R_T,  R_T);
            6'd38: u = mk_uop(OP_ADD,  R_S,   R_T,  R_S);
            // new wave value
            6'd39: u = mk_uop(OP_ADD,  R_L2,  R_L2, R_T);
            6'd40: u = mk_uop(OP_ADD,  R_L1,  R_T,  R_T);
            6'd41: u = mk_uop(OP_ADD,  R_L3,  R_L3, R_U);
            6'd42: u = mk_uop(OP_ADD,  R_U,   R_L4, R_U);
            6'd43: u = mk_uop(OP_ADD,  R_T,   R_U,  R_T);
            6'd44: u = mk_uop(OP_DIV6, R_T,   R_T,  R_T);
            6'd45: u = mk_uop(OP_ADD,  R_P,   R_T,  R_P);
            default: u = mk_uop(OP_ADD, R_T,  R_T,  R_T);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### rtl/rk4s_in_if.sv
`default_nettype none

interface rk4s_in_if
    import rk4s_pkg::*;
();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

### rtl/rk4s_out_if.sv
`default_nettype none

interface rk4s_out_if
    import rk4s_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] position;
    logic signed [FIELD_W-1:0] wave_out;
    logic signed [FIELD_W-1:0] slope_out;
    logic                      overflowed;

    modport source (output valid, output position, output wave_out, output slope_out,
                    output overflowed, input ready);
    modport sink (input valid, input position, input wave_out, input slope_out,
                  input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/rk4s_alu.sv
`default_nettype none

module rk4s_alu
    import rk4s_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire alu_req_t                    req,
    input  wire logic signed [WORD_BITS-1:0] a,
    input  wire logic signed [WORD_BITS-1:0] b,
    output alu_rsp_t                         rsp,
    output logic signed [WORD_BITS-1:0]      result
);

    localparam int W         = WORD_BITS;
    localparam int HW        = (W + 1) / 2;
    localparam int ACC_W     = 2 * W;
    localparam int MUL_LAST  = 5;
    localparam int CNT_W     = $clog2(MUL_LAST + 1);

    localparam logic [W-1:0]     WMAX_U     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     WMIN_U     = {1'b1, {(W-1){1'b0}}};
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    // ceil(2^W / 3): exact floor division by three for operands below 2^(W-1)
    localparam logic [W-1:0]     RECIP3     = W'(((ACC_W'(1) << W) + ACC_W'(2)) / ACC_W'(3));

    logic              busy_reg;
    logic [OP_W-1:0]   op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [W-1:0]      ma_reg;
    logic [W-1:0]      mb_reg;
    logic              neg_reg;
    logic [2*HW-1:0]   pp_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [W:0]        sum_ext;
    logic [W:0]        diff_ext;
    logic [W:0]        as_ext;
    logic              as_ovf;
    logic [W-1:0]      as_res;
    logic [W:0]        half_inc;
    logic [W-1:0]      half_res;

    logic [W-1:0]      mag_a;
    logic [W-1:0]      mag_b;
    logic              multi_start;
    logic [HW-1:0]     fa;
    logic [HW-1:0]     fb;
    logic [2*HW-1:0]   pp_next;
    logic [ACC_W-1:0]  pp_ext;
    logic [ACC_W-1:0]  pp_shift;
    logic [ACC_W-1:0]  mq;
    logic [ACC_W-1:0]  mlim;
    logic              m_ovf;
    logic [W-1:0]      m_mag;
    logic [W-1:0]      mul_res;

    logic [W:0]        div_num;
    logic [W-1:0]      div_q;
    logic [W-1:0]      div_res;

    logic              mul_done;
    logic              div_done;

    // Saturating add and subtract, rounded halving
    always_comb
    begin
        sum_ext  = {a[W-1], a} + {b[W-1], b};
        diff_ext = {a[W-1], a} - {b[W-1], b};
        as_ext   = (req.op == OP_SUB) ? diff_ext : sum_ext;
        as_ovf   = as_ext[W] != as_ext[W-1];
        as_res   = as_ovf ? (as_ext[W] ? WMIN_U : WMAX_U) : as_ext[W-1:0];
        half_inc = {1'b0, a} + (W+1)'(1);
        half_res = a[W-1] ? {a[W-1], a[W-1:1]} : half_inc[W:1];
    end

    // Operand magnitudes and the partial product of this cycle
    always_comb
    begin
        mag_a       = a[W-1] ? (~a + 1'b1) : a;
        mag_b       = b[W-1] ? (~b + 1'b1) : b;
        multi_start = req.start && ((req.op == OP_MUL) || (req.op == OP_DIV6));
        fa          = cnt_reg[1] ? HW'(ma_reg[W-1:HW]) : ma_reg[HW-1:0];
        fb          = cnt_reg[0] ? HW'(mb_reg[W-1:HW]) : mb_reg[HW-1:0];
        pp_next     = (2*HW)'(fa) * (2*HW)'(fb);
        pp_ext      = ACC_W'(pp_reg);
        case (cnt_reg)
            CNT_W'(1): pp_shift = pp_ext;
            CNT_W'(2): pp_shift = pp_ext << HW;
            CNT_W'(3): pp_shift = pp_ext << HW;
            CNT_W'(4): pp_shift = pp_ext << (2 * HW);
            default:   pp_shift = '0;
        endcase
    end

    // Round-to-nearest product is already in the accumulator; scale and clamp
    always_comb
    begin
        mq      = acc_reg >> FRAC_BITS;
        mlim    = ACC_W'(WMAX_U) + ACC_W'(neg_reg);
        m_ovf   = mq > mlim;
        m_mag   = mq[W-1:0];
        if (m_ovf)
        begin
            mul_res = neg_reg ? WMIN_U : WMAX_U;
        end
        else
        begin
            mul_res = neg_reg ? (~m_mag + 1'b1) : m_mag;
        end
    end

    // Divide by six: halve the rounded magnitude, multiply by RECIP3, keep the upper word
    always_comb
    begin
        div_num = (W+1)'(mag_a) + (W+1)'(3);
        div_q   = acc_reg[ACC_W-1:W];
        div_res = neg_reg ? (~div_q + 1'b1) : div_q;
    end

    assign mul_done = busy_reg && (op_reg == OP_MUL) && (cnt_reg == CNT_W'(MUL_LAST));
    assign div_done = busy_reg && (op_reg == OP_DIV6) && (cnt_reg == CNT_W'(MUL_LAST));

    // Sequence the multi-cycle operations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= OP_ADD;
            cnt_reg  <= '0;
        end
        else if (multi_start)
        begin
            busy_reg <= 1'b1;
            op_reg   <= req.op;
            cnt_reg  <= '0;
        end
        else if (mul_done || div_done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Shared multiplier datapath
    always_ff @(posedge clk)
    begin
        if (multi_start)
        begin
            if (req.op == OP_MUL)
            begin
                ma_reg  <= mag_a;
                mb_reg  <= mag_b;
                neg_reg <= a[W-1] != b[W-1];
            end
            else
            begin
                ma_reg  <= div_num[W:1];
                mb_reg  <= RECIP3;
                neg_reg <= a[W-1];
            end
        end
        else if (busy_reg)
        begin
            pp_reg <= pp_next;
            if (cnt_reg == '0)
            begin
                acc_reg <= (op_reg == OP_MUL) ? ROUND_HALF : '0;
            end
            else
            begin
                acc_reg <= acc_reg + pp_shift;
            end
        end
    end

    // Select the finished result
    always_comb
    begin
        rsp.done = 1'b0;
        rsp.sat  = 1'b0;
        result   = as_res;
        if (busy_reg)
        begin
            rsp.done = mul_done || div_done;
            if (op_reg == OP_MUL)
            begin
                result  = mul_res;
                rsp.sat = m_ovf;
            end
            else
            begin
                result = div_res;
            end
        end
        else
        begin
            unique case (req.op)
                OP_ADD, OP_SUB:
                begin
                    rsp.done = req.start;
                    rsp.sat  = as_ovf;
                    result   = as_res;
                end
                OP_HALF:
                begin
                    rsp.done = req.start;
                    result   = half_res;
                end
                default:
                begin
                    rsp.done = 1'b0;
                    result   = as_res;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/rk4_schrodinger_step.sv
`default_nettype none
// A restart transaction skips the shared unit; an advance transaction runs the microcoded
// step through it, and either result waits until the output register is free.
// One transaction at a time; the shared unit's multiply (four partial products), also
// used for both divides by six as a reciprocal product, sets the pace of an advance.
// Reset (async, active low): x = 0, psi = 0, slope = 1.0, overflow flag clear,
// energy = 0, step size = 0.001.

module rk4_schrodinger_step
    import rk4s_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    rk4s_in_if.sink                    cmd,
    rk4s_out_if.source                 status
);

    localparam int W = WORD_BITS;

    localparam logic [63:0]  WMAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - W + 1);
    localparam logic [63:0]  WMIN64 = ~WMAX64;
    localparam logic [W-1:0] ONE_W  = (FRAC_BITS >= W - 1) ? WMAX64[W-1:0]
                                                           : W'(64'd1 << FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      wait_reg;
    logic                      sat_reg;
    logic                      out_valid_reg;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic [STEP_SIZE_W-1:0]    step_size_reg;

    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] p_reg;
    logic signed [W-1:0] s_reg;
    logic signed [W-1:0] e_reg;
    logic signed [W-1:0] dx_reg;
    logic signed [W-1:0] t_reg;
    logic signed [W-1:0] u_reg;
    logic signed [W-1:0] xe_reg;
    logic signed [W-1:0] xme_reg;
    logic signed [W-1:0] xee_reg;
    logic signed [W-1:0] k1_reg;
    logic signed [W-1:0] k2_reg;
    logic signed [W-1:0] k3_reg;
    logic signed [W-1:0] k4_reg;
    logic signed [W-1:0] l1_reg;
    logic signed [W-1:0] l2_reg;
    logic signed [W-1:0] l3_reg;
    logic signed [W-1:0] l4_reg;

    logic signed [FIELD_W-1:0] pos_out_reg;
    logic signed [FIELD_W-1:0] wave_out_reg;
    logic signed [FIELD_W-1:0] slope_out_reg;
    logic                      ovf_out_reg;

    logic                cmd_acc;
    logic                out_free;
    logic                wb;
    logic                last_wb;
    uop_t                cur;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic signed [W-1:0] opa;
    logic signed [W-1:0] opb;
    logic signed [W-1:0] alu_res;
    logic signed [W-1:0] e_next;
    logic signed [W-1:0] dx_next;
    logic [63:0]         step64;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || status.ready;

    assign cur         = rk4s_uop(step_reg);
    assign alu_req.start = (state_reg == ST_RUN) && !wait_reg;
    assign alu_req.op    = cur.op;
    assign wb          = (state_reg == ST_RUN) && alu_rsp.done;
    assign last_wb     = wb && (step_reg == LAST_STEP);

    // Clamp the wide registers to the word range
    always_comb
    begin
        step64 = 64'(step_size_reg);
        if ($signed(energy_reg) > $signed(WMAX64))
        begin
            e_next = WMAX64[W-1:0];
        end
        else if ($signed(energy_reg) < $signed(WMIN64))
        begin
            e_next = WMIN64[W-1:0];
        end
        else
        begin
            e_next = energy_reg[W-1:0];
        end
        dx_next = (step64 > WMAX64) ? WMAX64[W-1:0] : step64[W-1:0];
    end

    // Operand A select
    always_comb
    begin
        unique case (cur.sa)
            R_X:     opa = x_reg;
            R_P:     opa = p_reg;
            R_S:     opa = s_reg;
            R_E:     opa = e_reg;
            R_DX:    opa = dx_reg;
            R_T:     opa = t_reg;
            R_U:     opa = u_reg;
            R_XE:    opa = xe_reg;
            R_XME:   opa = xme_reg;
            R_XEE:   opa = xee_reg;
            R_K1:    opa = k1_reg;
            R_K2:    opa = k2_reg;
            R_K3:    opa = k3_reg;
            R_K4:    opa = k4_reg;
            R_L1:    opa = l1_reg;
            R_L2:    opa = l2_reg;
            R_L3:    opa = l3_reg;
            R_L4:    opa = l4_reg;
            default: opa = t_reg;
        endcase
    end

    // Operand B select
    always_comb
    begin
        unique case (cur.sb)
            R_X:     opb = x_reg;
            R_P:     opb = p_reg;
            R_S:     opb = s_reg;
            R_E:     opb = e_reg;
            R_DX:    opb = dx_reg;
            R_T:     opb = t_reg;
            R_U:     opb = u_reg;
            R_XE:    opb = xe_reg;
            R_XME:   opb = xme_reg;
            R_XEE:   opb = xee_reg;
            R_K1:    opb = k1_reg;
            R_K2:    opb = k2_reg;
            R_K3:    opb = k3_reg;
            R_K4:    opb = k4_reg;
            R_L1:    opb = l1_reg;
            R_L2:    opb = l2_reg;
            R_L3:    opb = l3_reg;
            R_L4:    opb = l4_reg;
            default: opb = t_reg;
        endcase
    end

    rk4s_alu #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (opa),
        .b      (opb),
        .rsp    (alu_rsp),
        .result (alu_res)
    );

    // Sequencer, configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            wait_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
            step_size_reg <= STEP_SIZE_RESET;
            x_reg         <= '0;
            p_reg         <= '0;
            s_reg         <= ONE_W;
        end
        else
        begin
            // take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENERGY:    energy_reg    <= $signed(cfg_data[ENERGY_W-1:0]);
                    CFG_STEP_SIZE: step_size_reg <= cfg_data[STEP_SIZE_W-1:0];
                    default:       ;
                endcase
            end

            // load a finished result, or drop the one taken
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        if (cmd.restart)
                        begin
                            x_reg     <= '0;
                            p_reg     <= '0;
                            s_reg     <= ONE_W;
                            sat_reg   <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            step_reg  <= '0;
                            wait_reg  <= 1'b0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (alu_req.start && ((cur.op == OP_MUL) || (cur.op == OP_DIV6)))
                    begin
                        wait_reg <= 1'b1;
                    end
                    if (wb)
                    begin
                        wait_reg <= 1'b0;
                        if (alu_rsp.sat)
                        begin
                            sat_reg <= 1'b1;
                        end
                        if (cur.dst == R_S)
                        begin
                            s_reg <= alu_res;
                        end
                        if (cur.dst == R_P)
                        begin
                            p_reg <= alu_res;
                        end
                        if (last_wb)
                        begin
                            x_reg     <= xe_reg;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Latch clamped parameters, write back scratch results, load the result
    always_ff @(posedge clk)
    begin
        if (cmd_acc && !cmd.restart)
        begin
            e_reg  <= e_next;
            dx_reg <= dx_next;
        end
        if (wb)
        begin
            unique case (cur.dst)
                R_T:     t_reg   <= alu_res;
                R_U:     u_reg   <= alu_res;
                R_XE:    xe_reg  <= alu_res;
                R_XME:   xme_reg <= alu_res;
                R_XEE:   xee_reg <= alu_res;
                R_K1:    k1_reg  <= alu_res;
                R_K2:    k2_reg  <= alu_res;
                R_K3:    k3_reg  <= alu_res;
                R_K4:    k4_reg  <= alu_res;
                R_L1:    l1_reg  <= alu_res;
                R_L2:    l2_reg  <= alu_res;
                R_L3:    l3_reg  <= alu_res;
                R_L4:    l4_reg  <= alu_res;
                default: ;
            endcase
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            pos_out_reg   <= FIELD_W'(x_reg);
            wave_out_reg  <= FIELD_W'(p_reg);
            slope_out_reg <= FIELD_W'(s_reg);
            ovf_out_reg   <= sat_reg;
        end
    end

    assign status.valid      = out_valid_reg;
    assign status.position   = pos_out_reg;
    assign status.wave_out   = wave_out_reg;
    assign status.slope_out  = slope_out_reg;
    assign status.overflowed = ovf_out_reg;

endmodule

`default_nettype wire

### verif/rk4_schrodinger_step_test.sv
`timescale 1ns / 100ps

module rk4_schrodinger_step_test;
    import rk4s_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    typedef logic signed [FIELD_W-1:0] q_t;

    localparam q_t Q_ONE = q_t'(64'd1 << FRAC);
    localparam q_t Q_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [63:0] STEP_FIELD_MAX = (64'd1 << STEP_SIZE_W) - 64'd1;

    typedef struct {
        q_t   position;
        q_t   wave;
        q_t   slope;
        logic overflowed;
    } wave_state_t;

    // Tracks x, psi and psi' through RK4 steps and checks each status transaction
    class rk4_trajectory_check;
        q_t                     energy     = '0;
        logic [STEP_SIZE_W-1:0] dx_reg     = STEP_SIZE_RESET;
        q_t                     pos        = '0;
        q_t                     wave       = '0;
        q_t                     slope      = Q_ONE;
        logic                   ovf        = 1'b0;
        wave_state_t            trajectory_q[$];
        int                     errors     = 0;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
            if (idx == CFG_ENERGY)
                energy = value;
            else
                dx_reg = value[STEP_SIZE_W-1:0];
        endfunction

        // Saturating add and subtract; either sets the sticky flag on clamp
        function q_t add_sat(q_t a, q_t b);
            logic [FIELD_W:0] s;
            s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
            if (s[FIELD_W] != s[FIELD_W-1])
            begin
                ovf = 1'b1;
                return s[FIELD_W] ? Q_MIN : Q_MAX;
            end
            return s[FIELD_W-1:0];
        endfunction

        function q_t sub_sat(q_t a, q_t b);
            logic [FIELD_W:0] s;
            s = {a[FIELD_W-1], a} - {b[FIELD_W-1], b};
            if (s[FIELD_W] != s[FIELD_W-1])
            begin
                ovf = 1'b1;
                return s[FIELD_W] ? Q_MIN : Q_MAX;
            end
            return s[FIELD_W-1:0];
        endfunction

        // Fixed-point product, rounded half away from zero, clamped on overflow
        function q_t mul_q(q_t a, q_t b);
            logic         neg;
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] prod;
            logic [127:0] quo;
            logic [127:0] lim;
            neg  = a[63] ^ b[63];
            ma   = a[63] ? -a : a;
            mb   = b[63] ? -b : b;
            prod = {64'd0, ma} * {64'd0, mb};
            quo  = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
            lim  = neg ? {64'd0, 64'h8000_0000_0000_0000} : {64'd0, 64'h7FFF_FFFF_FFFF_FFFF};
            if (quo > lim)
            begin
                ovf = 1'b1;
                return neg ? Q_MIN : Q_MAX;
            end
            return neg ? -quo[63:0] : quo[63:0];
        endfunction

        function q_t div_six(q_t v);
            logic [63:0] m;
            logic [63:0] d;
            m = v[63] ? -v : v;
            d = (m + 64'd3) / 64'd6;
            return v[63] ? -d : d;
        endfunction

        // 2 (x - E) psi
        function q_t wave_accel(q_t x, q_t p, q_t e);
            q_t u;
            u = mul_q(sub_sat(x, e), p);
            return add_sat(u, u);
        endfunction

        function q_t rk4_sum(q_t base, q_t c1, q_t c2, q_t c3, q_t c4);
            q_t t;
            t = add_sat(add_sat(c1, add_sat(c2, c2)), add_sat(add_sat(c3, c3), c4));
            return add_sat(base, div_six(t));
        endfunction

        function void rk4_advance();
            q_t e, dx, half, xm, xe;
            q_t k1, k2, k3, k4, l1, l2, l3, l4;
            e    = energy;
            dx   = q_t'({{(FIELD_W-STEP_SIZE_W){1'b0}}, dx_reg});
            half = q_t'(64'd1 << (FRAC - 1));
            xm   = add_sat(pos, mul_q(dx, half));
            xe   = add_sat(pos, dx);
            k1   = mul_q(dx, wave_accel(pos, wave, e));
            l1   = mul_q(dx, slope);
            k2   = mul_q(dx, wave_accel(xm, add_sat(wave, mul_q(half, l1)), e));
            l2   = mul_q(dx, add_sat(slope, mul_q(half, k1)));
            k3   = mul_q(dx, wave_accel(xm, add_sat(wave, mul_q(half, l2)), e));
            l3   = mul_q(dx, add_sat(slope, mul_q(half, k2)));
            k4   = mul_q(dx, wave_accel(xe, add_sat(wave, l3), e));
            l4   = mul_q(dx, add_sat(slope, k3));
            slope = rk4_sum(slope, k1, k2, k3, k4);
            wave  = rk4_sum(wave, l1, l2, l3, l4);
            pos   = xe;
        endfunction

        function void note_command(logic restart);
            wave_state_t st;
            if (restart)
            begin
                pos   = '0;
                wave  = '0;
                slope = Q_ONE;
                ovf   = 1'b0;
            end
            else
                rk4_advance();
            st.position   = pos;
            st.wave       = wave;
            st.slope      = slope;
            st.overflowed = ovf;
            trajectory_q.push_back(st);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("%0t MISMATCH %s", $realtime, msg);
        endtask

        task check_status(q_t p, q_t w, q_t s, logic o);
            wave_state_t want;
            if (trajectory_q.size() == 0)
            begin
                report_mismatch("status transaction with nothing predicted");
                return;
            end
            want = trajectory_q.pop_front();
            if (p !== want.position)
                report_mismatch($sformatf("position got %h want %h", p, want.position));
            if (w !== want.wave)
                report_mismatch($sformatf("wave_out got %h want %h", w, want.wave));
            if (s !== want.slope)
                report_mismatch($sformatf("slope_out got %h want %h", s, want.slope));
            if (o !== want.overflowed)
                report_mismatch($sformatf("overflowed got %b want %b", o, want.overflowed));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rk4s_in_if  cmd_if ();
    rk4s_out_if status_if ();

    rk4_trajectory_check sb = new;

    int idle_pct = 10;
    int rx_hold  = 0;
    int rx_stall = 0;
    int cycles   = 0;
    int phase_kind [PHASES] = '{0, 0, 2, 0, 1, 3, 0, 2, 0, 1, 3, 0};

    rk4_schrodinger_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .status    (status_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one command transaction, with an optional idle burst ahead of it
    task automatic send_command(logic restart);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.restart <= restart;
        do @(posedge clk); while (!cmd_if.ready);
        sb.note_command(restart);
    endtask

    task automatic send_pattern(logic [7:0] pattern, int n);
        for (int i = 0; i < n; i++)
            send_command(pattern[i]);
    endtask

    // Drop valid and hold until every predicted status has arrived
    task automatic drain_results();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (sb.trajectory_q.size() != 0) @(posedge clk);
    endtask

    task automatic configure(q_t e, logic [63:0] step_word);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENERGY;
        cfg_data  <= e;
        @(posedge clk);
        sb.write_register(CFG_ENERGY, e);
        @(negedge clk);
        cfg_index <= CFG_STEP_SIZE;
        cfg_data  <= step_word;
        @(posedge clk);
        sb.write_register(CFG_STEP_SIZE, step_word);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Check every accepted status transaction
    always @(posedge clk)
    begin
        if (rst_n && status_if.valid && status_if.ready)
            sb.check_status(status_if.position, status_if.wave_out, status_if.slope_out,
                            status_if.overflowed);
    end

    // Status ready: long hold-off on request, otherwise random stall bursts
    initial
    begin
        status_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                status_if.ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                status_if.ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 499) < idle_pct)
            begin
                rx_stall = $urandom_range(1, 17) - 1;
                status_if.ready <= 1'b0;
            end
            else
                status_if.ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        q_t          e;
        logic [63:0] step_word;
        int          run_left;
        logic        r;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ENERGY;
        cfg_data       = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.restart = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset state and default settings, then extreme settings
        send_pattern(8'b0000_1000, 5);
        configure(Q_MAX, 64'd1 << FRAC);
        send_pattern(8'b0000_0100, 4);
        // zero step keeps the state, energy at the low end saturates x - E
        configure(Q_MIN, 64'd0);
        send_pattern(8'b0000_0100, 4);
        configure('0, 64'd1);
        send_pattern(8'b0000_0001, 3);
        configure(q_t'(-1), STEP_FIELD_MAX);
        send_pattern(8'b0000_0000, 2);

        // Random phases: restart followed by runs of advances, plus some noise
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (phase_kind[ph])
                0:
                begin
                    e         = rand64() % (64'd12 << FRAC);
                    step_word = 64'($urandom_range(1, 1 << 20)) << $urandom_range(10, 20);
                end
                1:
                begin
                    e         = rand64();
                    step_word = rand64();
                end
                2:
                begin
                    case ($urandom_range(0, 4))
                        0:       e = Q_MAX;
                        1:       e = Q_MIN;
                        2:       e = '0;
                        3:       e = q_t'(-1);
                        default: e = q_t'(64'd3 << FRAC);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       step_word = 64'd0;
                        1:       step_word = 64'd1;
                        2:       step_word = 64'd1 << FRAC;
                        3:       step_word = STEP_FIELD_MAX;
                        default: step_word = 64'(STEP_SIZE_RESET);
                    endcase
                end
                default:
                begin
                    e         = -q_t'(rand64() % (64'd4 << FRAC));
                    step_word = 64'($urandom_range(1, 1 << 24)) << $urandom_range(4, 16);
                end
            endcase
            configure(e, step_word);

            if (ph == PHASES - 1)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            if (ph == 6)
                rx_hold = 4000;

            run_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (run_left == 0)
                begin
                    r        = 1'b1;
                    run_left = $urandom_range(0, 40);
                end
                else
                begin
                    r = 1'b0;
                    run_left--;
                end
                if ($urandom_range(0, 19) == 0)
                    r = ~r;
                send_command(r);
            end
        end

        drain_results();
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
